[rtl/core/dcss_pkg.sv]
// Shared types, constants and lookup functions for the seven-segment down counter.
package dcss_pkg;

    localparam int unsigned CountW = 14;
    localparam int unsigned FrameW = 8;
    localparam int unsigned DebW   = 4;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDataW = 14;

    localparam logic [CountW-1:0] MaxCount = 14'd9999;

    localparam logic [CfgIdxW-1:0] RegInitialCount   = 8'd0;
    localparam logic [CfgIdxW-1:0] RegNormalFrames   = 8'd1;
    localparam logic [CfgIdxW-1:0] RegFastFrames     = 8'd2;
    localparam logic [CfgIdxW-1:0] RegDebounceSamples = 8'd3;

    localparam logic [3:0] AnodeBlank = 4'hF;
    localparam logic [7:0] SegBlank   = 8'hFF;

    typedef struct packed {
        logic [3:0]        anode_enable;
        logic [7:0]        segments;
        logic [CountW-1:0] shown_count;
        logic              last_slot;
    } t_slot;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SegBlank;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] anode_code(input logic [1:0] slot);
        logic [3:0] code;
        case (slot)
            2'd0:    code = 4'hE;
            2'd1:    code = 4'hD;
            2'd2:    code = 4'hB;
            default: code = 4'h7;
        endcase
        return code;
    endfunction

    // m times the place weight of the slot (thousands, hundreds, tens, ones)
    function automatic logic [CountW-1:0] place_mult(input logic [1:0] slot,
                                                     input logic [3:0] m);
        logic [CountW-1:0] w;
        logic [CountW+3:0] p;
        case (slot)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        p = w * m;
        return p[CountW-1:0];
    endfunction

endpackage

[rtl/core/dcss_front.sv]
// Front end: configuration registers, frame state update and job issue per display frame.
module dcss_front
    import dcss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic [4:0]          i_buttons,
    output logic                o_push,
    output logic [CountW-1:0]   o_value
);

    logic [CountW-1:0] r_initial_count;
    logic [FrameW-1:0] r_normal_frames;
    logic [FrameW-1:0] r_fast_frames;
    logic [DebW-1:0]   r_debounce_samples;

    logic              r_running, n_running;
    logic              r_stopped, n_stopped;
    logic [CountW:0]   r_current, n_current;
    logic [CountW-1:0] r_preset, n_preset;
    logic              r_fast, n_fast;
    logic              r_deb_level, n_deb_level;
    logic [DebW-1:0]   r_deb_run, n_deb_run;
    logic [FrameW-1:0] r_frame, n_frame;

    logic              start_b, stop_b, reset_b, prog_b, speed_b;
    logic [CountW-1:0] src;
    logic [CountW-1:0] val;
    logic [DebW-1:0]   need;
    logic [FrameW-1:0] limit;

    assign start_b = i_buttons[0];
    assign stop_b  = i_buttons[1];
    assign reset_b = i_buttons[2];
    assign prog_b  = i_buttons[3];
    assign speed_b = i_buttons[4];

    always_comb begin
        n_running   = r_running;
        n_stopped   = r_stopped;
        n_current   = r_current;
        n_preset    = r_preset;
        n_fast      = r_fast;
        n_deb_level = r_deb_level;
        n_deb_run   = r_deb_run;
        n_frame     = r_frame;
        src         = (r_preset == '0) ? r_initial_count : r_preset;
        val         = '0;
        need        = (r_debounce_samples == '0) ? DebW'(1) : r_debounce_samples;
        limit       = '0;

        if (r_frame == '0) begin
            if (start_b) begin
                n_running = 1'b1;
                n_stopped = 1'b0;
            end
            if (n_running && (r_current[CountW] || reset_b)) begin
                n_current = {1'b0, (src > MaxCount) ? MaxCount : src};
            end
        end

        if (n_running) begin
            val = n_current[CountW] ? '0 : n_current[CountW-1:0];

            if (speed_b != r_deb_level) begin
                n_deb_run = r_deb_run + DebW'(1);
                if (n_deb_run >= need) begin
                    n_deb_level = speed_b;
                    if (speed_b) begin
                        n_fast = ~r_fast;
                    end
                    n_deb_run = '0;
                end
            end else begin
                n_deb_run = '0;
            end

            limit = n_fast ? r_fast_frames : r_normal_frames;
            if (limit == '0) begin
                limit = FrameW'(1);
            end
            if (prog_b && !n_fast) begin
                n_preset = val;
            end
            if (stop_b) begin
                n_stopped = 1'b1;
            end

            n_frame = r_frame + FrameW'(1);
            if (n_frame >= limit || n_frame == '0) begin
                n_frame = '0;
                if (!n_stopped) begin
                    n_current = n_current - (CountW+1)'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_count    <= MaxCount;
            r_normal_frames    <= 8'd50;
            r_fast_frames      <= 8'd1;
            r_debounce_samples <= 4'd4;
            r_running          <= 1'b0;
            r_stopped          <= 1'b0;
            r_current          <= {1'b0, MaxCount};
            r_preset           <= MaxCount;
            r_fast             <= 1'b0;
            r_deb_level        <= 1'b0;
            r_deb_run          <= '0;
            r_frame            <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegInitialCount:    r_initial_count    <= i_cfg_data[CountW-1:0];
                    RegNormalFrames:    r_normal_frames    <= i_cfg_data[FrameW-1:0];
                    RegFastFrames:      r_fast_frames      <= i_cfg_data[FrameW-1:0];
                    RegDebounceSamples: r_debounce_samples <= i_cfg_data[DebW-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_running   <= n_running;
                r_stopped   <= n_stopped;
                r_current   <= n_current;
                r_preset    <= n_preset;
                r_fast      <= n_fast;
                r_deb_level <= n_deb_level;
                r_deb_run   <= n_deb_run;
                r_frame     <= n_frame;
            end
        end
    end

    assign o_push  = i_accept && n_running;
    assign o_value = val;

endmodule

[rtl/core/dcss_queue.sv]
// Two-entry job queue between the frame front end and the digit scan back end.
module dcss_queue
    import dcss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [CountW-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [CountW-1:0] o_data
);

    logic [CountW-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

endmodule

[rtl/core/dcss_back.sv]
// Back end: one decimal digit per cycle while the output is not stalled, blanking and registered slot output.
module dcss_back
    import dcss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  logic [CountW-1:0] i_job_value,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output t_slot             o_slot
);

    logic              r_busy;
    logic [CountW-1:0] r_rem;
    logic [1:0]        r_idx;
    logic              r_blank;
    logic [CountW-1:0] r_val;
    logic              r_ovalid;
    t_slot             r_oslot;

    logic              act_valid;
    logic [CountW-1:0] act_rem;
    logic [1:0]        act_idx;
    logic              act_blank;
    logic [CountW-1:0] act_val;
    logic              fire;
    logic [3:0]        digit;
    logic [CountW-1:0] sub;
    logic [CountW-1:0] thr;
    logic              blank_now;

    always_comb begin
        act_valid = r_busy ? 1'b1    : i_job_valid;
        act_rem   = r_busy ? r_rem   : i_job_value;
        act_idx   = r_busy ? r_idx   : 2'd0;
        act_blank = r_busy ? r_blank : 1'b1;
        act_val   = r_busy ? r_val   : i_job_value;
        fire      = act_valid && (!r_ovalid || i_ready);

        digit = '0;
        sub   = '0;
        thr   = '0;
        for (int m = 1; m <= 9; m++) begin
            thr = place_mult(act_idx, 4'(m));
            if (act_rem >= thr) begin
                digit = 4'(m);
                sub   = thr;
            end
        end
        blank_now = act_blank && (digit == '0) && (act_idx != 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (fire) begin
                r_busy   <= (act_idx != 2'd3);
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rem   <= act_rem - sub;
            r_idx   <= act_idx + 2'd1;
            r_blank <= blank_now;
            r_val   <= act_val;
            r_oslot.anode_enable <= blank_now ? AnodeBlank : anode_code(act_idx);
            r_oslot.segments     <= blank_now ? SegBlank : seg_code(digit);
            r_oslot.shown_count  <= act_val;
            r_oslot.last_slot    <= (act_idx == 2'd3);
        end
    end

    assign o_pop   = fire && !r_busy;
    assign o_valid = r_ovalid;
    assign o_slot  = r_oslot;

endmodule

[rtl/core/down_counter_seven_segment_scan_core.sv]
// Top level of the four-digit seven-segment down counter with display scan.
//
// Usage:
//   Slave stream: one item per display frame, tdata carries the five button
//   levels. The front end updates the counter state in the accept cycle and,
//   once running, queues the displayed count for the scan back end.
//   Master stream: four items per running frame, thousands to ones, each with
//   an active-low anode enable, segment pattern and displayed count; tlast
//   marks the ones slot. Frames before the first start press give no items.
//   Configuration: write channel (index, data), always ready; write only while
//   the block is idle.
// Path: the accepted count is written into the two-entry queue, and the back
//   end then registers the thousands slot into the output slot.
// Throughput: four slots per running frame, set by the back end emitting one
//   digit slot per cycle while tready is high; frames that produce no slots
//   are taken every cycle while the two-entry queue has room.
// Reset: synchronous, active low; configuration returns to 9999/50/1/4, the
//   counter is not running and no item is pending.
// Stall: a low tready holds the output slot; the back end and then the queue
//   fill, after which tready on the slave side drops.
module down_counter_seven_segment_scan_core
    import dcss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // start, stop, reset, program, speed, 3'b0
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata,   // anode_enable[3:0], segments[11:4],
                                             // shown_count[25:12], 6'b0
    output logic                o_m_tlast,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic              accept;
    logic              push;
    logic [CountW-1:0] push_value;
    logic              q_full;
    logic              q_valid;
    logic [CountW-1:0] q_data;
    logic              pop;
    t_slot             slot;

    assign o_s_tready  = !q_full;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    dcss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_buttons   (i_s_tdata[4:0]),
        .o_push      (push),
        .o_value     (push_value)
    );

    dcss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_value),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    dcss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job_value (q_data),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_slot      (slot)
    );

    assign o_m_tdata = {6'b0, slot.shown_count, slot.segments, slot.anode_enable};
    assign o_m_tlast = slot.last_slot;

endmodule
